/* rtl/core/sstf_pkg.sv */
package sstf_pkg;

	// default store depth
	localparam int unsigned QUEUE_DEPTH_DEF = 32;

	// request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_START = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_SERVED = 2'd0;
	localparam logic [1:0] STAT_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;

	// input item
	typedef struct packed {
		logic        req_type;
		logic [15:0] track_number;
		logic [15:0] init_head;
	} req_t;

	// result item
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] served_track;
		logic [15:0] seek_distance;
		logic [21:0] total_movement;
		logic        last_of_run;
	} rsp_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESP,
		ST_SCAN,
		ST_PICK
	} state_t;

	// control from the sequencer to the distance comparator
	typedef struct packed {
		logic clear;
		logic en;
		logic skip;
	} cmp_ctl_t;

endpackage

/* rtl/core/sstf_seek_scheduler_unit.sv */
// Shortest-seek-first request scheduler.
// Request channel (req_valid / req_stall / req): a load item appends one track
// to a store of QUEUE_DEPTH entries and yields no result; a load
// into a full store yields one result with status full. A start item sets the
// head and serves every stored track once, nearest first (ties go to the
// higher entry), then empties the store; with nothing stored it yields one
// result with status empty.
// Result channel (rsp_valid / rsp_stall / rsp): one registered output stage;
// last_of_run marks the final result of an item.
// For each pick, one comparator walks the store through its single registered
// read port, then the result is issued; req_stall stays high for the whole run.
// When the receiver stalls, the finished result holds and the sequencer waits
// before issuing the next one. Reset empties the store, zeroes the head and
// the movement sum, and leaves the output empty.
module sstf_seek_scheduler_unit #(
	parameter int unsigned QUEUE_DEPTH = sstf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sstf_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sstf_pkg::rsp_t rsp
);

	import sstf_pkg::*;

	localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic [CNT_W-1:0] picks_q;
	logic [15:0]      head_q;
	logic [22:0]      sum_q;
	logic [22:0]      sum_next;
	logic [QUEUE_DEPTH-1:0] visited_q;
	logic [1:0]       resp_stat_q;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             accept;
	logic             is_load;
	logic             full;
	logic             rsp_free;
	logic             scan_done;
	logic             last_pick;
	logic             ram_we;
	logic             ram_re;
	logic             resp_fire;
	logic             pick_fire;
	logic             scan_start;
	logic [15:0]      rd_track;

	cmp_ctl_t         cmp_ctl;
	logic             best_found;
	logic [IDX_W-1:0] best_idx;
	logic [15:0]      best_track;
	logic [15:0]      best_dist;

	// common conditions
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign is_load   = (req.req_type == REQ_LOAD);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign scan_done = (scan_idx_q == count_q) && !rd_valid_s1;
	assign last_pick = (picks_q == count_q - CNT_W'(1));
	assign sum_next  = sum_q + {7'd0, best_dist};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (is_load) begin
						state_d = full ? ST_RESP : ST_IDLE;
					end else begin
						state_d = (count_q == '0) ? ST_RESP : ST_SCAN;
					end
				end
			end
			ST_RESP: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				if (rsp_free) begin
					state_d = last_pick ? ST_IDLE : ST_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		resp_fire  = 1'b0;
		pick_fire  = 1'b0;
		scan_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ram_we     = accept && is_load && !full;
				scan_start = accept && !is_load;
			end
			ST_RESP: begin
				resp_fire = rsp_free;
			end
			ST_SCAN: begin
				ram_re = (scan_idx_q < count_q);
			end
			ST_PICK: begin
				pick_fire  = rsp_free;
				scan_start = rsp_free && !last_pick;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// track store
	sstf_ram #(
		.WIDTH(16),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(req.track_number),
		.re   (ram_re),
		.raddr(scan_idx_q[IDX_W-1:0]),
		.rdata(rd_track)
	);

	// shared distance comparator
	assign cmp_ctl.clear = scan_start;
	assign cmp_ctl.en    = rd_valid_s1;
	assign cmp_ctl.skip  = visited_q[rd_idx_s1];

	sstf_cmp #(
		.IDX_W(IDX_W)
	) u_cmp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (cmp_ctl),
		.idx       (rd_idx_s1),
		.head      (head_q),
		.track     (rd_track),
		.best_found(best_found),
		.best_idx  (best_idx),
		.best_track(best_track),
		.best_dist (best_dist)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_idx_q  <= '0;
			picks_q     <= '0;
			head_q      <= '0;
			sum_q       <= '0;
			visited_q   <= '0;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= ram_re;
			if (ram_we) begin
				count_q                       <= count_q + CNT_W'(1);
				visited_q[count_q[IDX_W-1:0]] <= 1'b0;
			end
			if (ram_re) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			// new run
			if (accept && !is_load) begin
				head_q    <= req.init_head;
				sum_q     <= '0;
				picks_q   <= '0;
				visited_q <= '0;
			end
			if (scan_start) begin
				scan_idx_q <= '0;
			end
			// one service
			if (pick_fire) begin
				head_q  <= best_track;
				sum_q   <= sum_next;
				picks_q <= picks_q + CNT_W'(1);
				if (last_pick) begin
					count_q   <= '0;
					visited_q <= '0;
				end else begin
					visited_q[best_idx] <= 1'b1;
				end
			end
			// output stage
			if (resp_fire || pick_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
		if (accept) begin
			resp_stat_q <= is_load ? STAT_FULL : STAT_EMPTY;
		end
		if (resp_fire) begin
			rsp_q.status         <= resp_stat_q;
			rsp_q.served_track   <= '0;
			rsp_q.seek_distance  <= '0;
			rsp_q.total_movement <= '0;
			rsp_q.last_of_run    <= 1'b1;
		end else if (pick_fire) begin
			rsp_q.status         <= STAT_SERVED;
			rsp_q.served_track   <= best_track;
			rsp_q.seek_distance  <= best_dist;
			rsp_q.total_movement <= sum_next[21:0];
			rsp_q.last_of_run    <= last_pick;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("store count beyond depth");

	a_pick_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PICK |-> best_found)
		else $error("pick without a candidate");

	a_picks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_PICK) |-> picks_q < count_q)
		else $error("more picks than stored tracks");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_idx_q <= count_q)
		else $error("scan index past the store");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_load && !full) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("load did not grow the store");

endmodule

/* rtl/core/sstf_ram.sv */
module sstf_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/sstf_cmp.sv */
module sstf_cmp #(
	parameter int unsigned IDX_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sstf_pkg::cmp_ctl_t ctl,
	input  logic [IDX_W-1:0] idx,
	input  logic [15:0]      head,
	input  logic [15:0]      track,
	output logic             best_found,
	output logic [IDX_W-1:0] best_idx,
	output logic [15:0]      best_track,
	output logic [15:0]      best_dist
);

	import sstf_pkg::*;

	logic [15:0] trk_dist;
	logic        take;
	logic        found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [15:0] best_track_q;
	logic [15:0] best_dist_q;

	// absolute distance from the head, ties go to the later index
	assign trk_dist = (head >= track) ? (head - track) : (track - head);
	assign take = ctl.en && !ctl.skip && (!found_q || trk_dist <= best_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// best candidate so far
	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q   <= idx;
			best_track_q <= track;
			best_dist_q  <= trk_dist;
		end
	end

	assign best_found = found_q;
	assign best_idx   = best_idx_q;
	assign best_track = best_track_q;
	assign best_dist  = best_dist_q;

endmodule

/* dv/tb_sstf_seek_scheduler_unit.sv */
module tb_sstf_seek_scheduler_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sstf_pkg::*;

	localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// tracks waiting for the next start, head and service order expected
	logic [15:0] pending_tracks[$];
	logic [15:0] head_pos;
	rsp_t expected_services[$];

	// bookkeeping
	int unsigned err_count = 0;
	int unsigned n_items = 0;
	int unsigned n_runs = 0;
	int unsigned n_full = 0;
	int unsigned n_empty = 0;
	int unsigned n_checked = 0;

	// idling control
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	int unsigned hold_req = 0;

	sstf_seek_scheduler_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// end the run if the block hangs
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// mostly short idle stretches, a few long ones
	function automatic int unsigned idle_len();
		if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// shortest seek first, ties to the highest entry
	function automatic void predict_item(req_t it);
		rsp_t r;
		bit served [DEPTH];
		int best;
		logic [15:0] best_d;
		logic [15:0] d;
		logic [22:0] move_sum;
		int n;
		r = '0;
		if (it.req_type == REQ_LOAD) begin
			if (pending_tracks.size() >= DEPTH) begin
				r.status = STAT_FULL;
				r.last_of_run = 1'b1;
				expected_services.push_back(r);
				n_full++;
			end else begin
				pending_tracks.push_back(it.track_number);
			end
			return;
		end
		head_pos = it.init_head;
		move_sum = '0;
		n = pending_tracks.size();
		if (n == 0) begin
			r.status = STAT_EMPTY;
			r.last_of_run = 1'b1;
			expected_services.push_back(r);
			n_empty++;
			return;
		end
		n_runs++;
		foreach (served[i]) served[i] = 1'b0;
		for (int p = 0; p < n; p++) begin
			best = -1;
			best_d = '0;
			for (int i = 0; i < n; i++) begin
				if (!served[i]) begin
					d = (head_pos >= pending_tracks[i]) ? head_pos - pending_tracks[i]
						: pending_tracks[i] - head_pos;
					if (best < 0 || d <= best_d) begin
						best = i;
						best_d = d;
					end
				end
			end
			move_sum = move_sum + {7'd0, best_d};
			head_pos = pending_tracks[best];
			served[best] = 1'b1;
			r.status = STAT_SERVED;
			r.served_track = head_pos;
			r.seek_distance = best_d;
			r.total_movement = move_sum[21:0];
			r.last_of_run = (p == n - 1);
			expected_services.push_back(r);
		end
		pending_tracks.delete();
	endfunction

	function automatic void report_err(string what, logic [31:0] want, logic [31:0] got);
		err_count++;
		if (err_count <= 10)
			$display("mismatch at %0t, result %0d: %s expected 0x%0h got 0x%0h",
				$time, n_checked, what, want, got);
	endfunction

	// compare one result against the oldest expectation
	function automatic void check_result(rsp_t got);
		rsp_t want;
		n_checked++;
		if (expected_services.size() == 0) begin
			report_err("unexpected result, status", 32'hFFFF_FFFF, 32'(got.status));
			return;
		end
		want = expected_services.pop_front();
		if (got.status !== want.status)
			report_err("status", 32'(want.status), 32'(got.status));
		if (got.served_track !== want.served_track)
			report_err("served_track", 32'(want.served_track), 32'(got.served_track));
		if (got.seek_distance !== want.seek_distance)
			report_err("seek_distance", 32'(want.seek_distance), 32'(got.seek_distance));
		if (got.total_movement !== want.total_movement)
			report_err("total_movement", 32'(want.total_movement),
				32'(got.total_movement));
		if (got.last_of_run !== want.last_of_run)
			report_err("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
	endfunction

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) check_result(rsp);
	end

	// receiver stall pattern, with long hold-offs on request
	initial begin
		int unsigned hold_left;
		int unsigned run_left;
		bit stall_state;
		hold_left = 0;
		run_left = 0;
		stall_state = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (rx_quiet) begin
				rsp_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					stall_state = ($urandom_range(0, 2) == 0);
					run_left = stall_state ? idle_len() : $urandom_range(1, 12);
				end
				run_left--;
				rsp_stall <= stall_state;
			end
		end
	end

	// offer one item and wait until it is taken
	task automatic send_item(input req_t it);
		int unsigned gap;
		gap = 0;
		if (!tx_quiet && $urandom_range(0, 99) >= 55) gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_item(it);
		n_items++;
	endtask

	task automatic send_load(input logic [15:0] trk);
		req_t it;
		it.req_type = REQ_LOAD;
		it.track_number = trk;
		it.init_head = 16'($urandom());
		send_item(it);
	endtask

	task automatic send_start(input logic [15:0] head);
		req_t it;
		it.req_type = REQ_START;
		it.track_number = 16'($urandom());
		it.init_head = head;
		send_item(it);
	endtask

	// start with nothing loaded
	task automatic test_empty_start();
		send_start(16'hFFFF);
		send_start(16'h0000);
	endtask

	// track and head extremes
	task automatic test_extremes();
		send_load(16'h0000);
		send_load(16'hFFFF);
		send_load(16'h8000);
		send_start(16'hFFFF);
		send_load(16'hFFFF);
		send_load(16'h0001);
		send_start(16'h0000);
	endtask

	// equal distances go to the higher entry, duplicates and zero seeks
	task automatic test_ties();
		send_load(16'd10);
		send_load(16'd30);
		send_start(16'd20);
		send_load(16'd200);
		send_load(16'd100);
		send_load(16'd300);
		send_start(16'd200);
		send_load(16'd5);
		send_load(16'd5);
		send_load(16'd5);
		send_start(16'd5);
	endtask

	// fill the store, then overflow it
	task automatic test_full_store();
		repeat (DEPTH) send_load(16'($urandom()));
		send_load(16'hFFFF);
		send_load(16'h0000);
		send_start(16'($urandom()));
	endtask

	// receiver holds off during a full run while items keep coming
	task automatic test_backpressure();
		tx_quiet = 1'b1;
		repeat (DEPTH) send_load(16'($urandom_range(0, 255)));
		hold_req = 300;
		send_start(16'd128);
		repeat (4) send_load(16'($urandom()));
		send_start(16'($urandom()));
		tx_quiet = 1'b0;
	endtask

	function automatic logic [15:0] pick_track(int unsigned mode, logic [15:0] centre);
		case (mode)
			0: return 16'($urandom());
			1: return 16'(centre + $urandom_range(0, 16) - 8);
			default: return $urandom_range(0, 1) ? 16'(16'hFFFF - $urandom_range(0, 3))
				: 16'($urandom_range(0, 3));
		endcase
	endfunction

	// load sequences with random content, mostly closed by a start
	task automatic test_random_runs();
		int unsigned sent;
		int unsigned nloads;
		int unsigned mode;
		int unsigned r;
		bit do_start;
		logic [15:0] centre;
		sent = 0;
		while (sent < 20) begin
			tx_quiet = ($urandom_range(0, 6) == 0);
			rx_quiet = ($urandom_range(0, 6) == 0);
			mode = $urandom_range(0, 2);
			centre = 16'($urandom());
			r = $urandom_range(0, 99);
			if (r < 85) begin
				do_start = 1'b1;
				r = $urandom_range(0, 99);
				if (r < 70) nloads = $urandom_range(1, 6);
				else if (r < 93) nloads = $urandom_range(7, 16);
				else nloads = $urandom_range(30, 35);
			end else begin
				do_start = ($urandom_range(0, 1) != 0);
				nloads = $urandom_range(0, 2);
			end
			repeat (nloads) begin
				send_load(pick_track(mode, centre));
				sent++;
			end
			if (do_start) begin
				send_start(pick_track(mode, centre));
				sent++;
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		head_pos = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_start();
		test_extremes();
		test_ties();
		test_full_store();
		test_backpressure();
		test_random_runs();

		// drain and watch for stray results
		@(negedge clk);
		req_valid <= 1'b0;
		rx_quiet = 1'b1;
		while (expected_services.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("covered %0d items: %0d scheduling runs, %0d empty starts, %0d dropped loads",
			n_items, n_runs, n_empty, n_full);
		$display("compared %0d results, %0d field errors", n_checked, err_count);
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
